FILE: rtl/fbde_pkg.sv
// ----------------------------------------------------------------------------
// fbde_pkg: shared types and helpers for the frame buffer drawing engine
// Command codes, configuration register indexes, font step tables and the
// RGB565 component expansion used on pixel read-back.
// ----------------------------------------------------------------------------
`default_nettype none

package fbde_pkg;

    typedef enum logic [2:0] {
        CMD_PIXEL       = 3'd0,
        CMD_FILL_RECT   = 3'd1,
        CMD_FILL_SCREEN = 3'd2,
        CMD_DRAW_CHAR   = 3'd3,
        CMD_READ_PIXEL  = 3'd4,
        CMD_LOAD_GLYPH  = 3'd5
    } t_cmd;

    typedef enum logic {
        REG_FONT_WIDTH  = 1'b0,
        REG_FONT_HEIGHT = 1'b1
    } t_reg;

    localparam logic [4:0] FONT_W_RESET = 5'd16;
    localparam logic [5:0] FONT_H_RESET = 6'd32;

    // ceil(2^20 / 31) and ceil(2^20 / 63): exact truncating division for
    // the products that 5- and 6-bit components can reach
    localparam logic [15:0] RECIP_31 = 16'd33826;
    localparam logic [14:0] RECIP_63 = 15'd16645;

    // glyph row step 32 / h, with h clamped to 1..32
    function automatic logic [5:0] row_step(input logic [5:0] h);
        logic [5:0] rs;
        case (h) inside
            6'd0, 6'd1: rs = 6'd32;
            6'd2:       rs = 6'd16;
            6'd3:       rs = 6'd10;
            6'd4:       rs = 6'd8;
            6'd5:       rs = 6'd6;
            6'd6:       rs = 6'd5;
            6'd7, 6'd8: rs = 6'd4;
            6'd9, 6'd10: rs = 6'd3;
            [6'd11:6'd16]: rs = 6'd2;
            default:    rs = 6'd1;
        endcase
        return rs;
    endfunction

    // glyph column step 16 / w, with w clamped to 1..16
    function automatic logic [4:0] col_step(input logic [4:0] w);
        logic [4:0] cs;
        case (w) inside
            5'd0, 5'd1:  cs = 5'd16;
            5'd2:        cs = 5'd8;
            5'd3:        cs = 5'd5;
            5'd4:        cs = 5'd4;
            5'd5:        cs = 5'd3;
            [5'd6:5'd8]: cs = 5'd2;
            default:     cs = 5'd1;
        endcase
        return cs;
    endfunction

    function automatic logic [5:0] font_h_eff(input logic [5:0] h);
        logic [5:0] he;
        if (h == 6'd0) begin
            he = 6'd1;
        end else if (h > 6'd32) begin
            he = 6'd32;
        end else begin
            he = h;
        end
        return he;
    endfunction

    // v * 255 / 31, truncated
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [12:0] p;
        logic [28:0] q;
        p = {v, 8'd0} - 13'(v);
        q = 29'(p) * 29'(RECIP_31);
        return q[27:20];
    endfunction

    // v * 255 / 63, truncated
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] p;
        logic [29:0] q;
        p = {v, 8'd0} - 14'(v);
        q = 30'(p) * 30'(RECIP_63);
        return q[27:20];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fbde_ram.sv
// ----------------------------------------------------------------------------
// fbde_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fbde_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [DATA_W-1:0]                      o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/framebuffer_draw_engine.sv
// Pixel write and glyph row load: next transfer taken at once.
// Pixel read: frame RAM read in ST_RD_ADDR, result registered once the output is free.
// Rectangle and screen fill: one frame RAM write per cycle over the clipped area.
// Character: per drawn glyph row a glyph RAM read, then one pixel op per column.
// Reset: a clearing pass writes zero to all SCREEN_WIDTH*SCREEN_HEIGHT pixels;
// no input transfer meanwhile, config still taken.
// ----------------------------------------------------------------------------
// framebuffer_draw_engine: RGB565 frame buffer with glyph store
// Sequencer emits one pixel op per cycle into a register stage that drives
// the frame RAM; glyph rows come from a second RAM. All frame accesses pass
// through the same in-order stage, so no forwarding is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320,
    parameter int GLYPH_COUNT   = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_a, y_a, x_b, y_b, color, char_code, glyph_row, glyph_bits, zero pad
    input  wire logic [87:0] s_axis_tdata,
    // command
    input  wire logic [2:0]  s_axis_tuser,
    // read-back stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_raw, read_red, read_green, read_blue
    output logic      [39:0] m_axis_tdata,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [5:0]  i_cfg_data
);

    localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FA_W     = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
    localparam int G_DEPTH  = GLYPH_COUNT * 32;
    localparam int GA_W     = $clog2(G_DEPTH);
    localparam logic [8:0] SCR_W = 9'(SCREEN_WIDTH);
    localparam logic [8:0] SCR_H = 9'(SCREEN_HEIGHT);
    localparam logic [8:0] GLYPHS = 9'(GLYPH_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CHAR_WAIT,
        ST_CHAR_COLS,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_HOLD
    } t_state;

    // input fields
    fbde_pkg::t_cmd in_cmd;
    logic [8:0]  in_x_a, in_y_a, in_x_b, in_y_b;
    logic [15:0] in_color, in_glyph_bits;
    logic [7:0]  in_code;
    logic [4:0]  in_glyph_row;

    assign in_cmd        = fbde_pkg::t_cmd'(s_axis_tuser);
    assign in_x_a        = s_axis_tdata[8:0];
    assign in_y_a        = s_axis_tdata[17:9];
    assign in_x_b        = s_axis_tdata[26:18];
    assign in_y_b        = s_axis_tdata[35:27];
    assign in_color      = s_axis_tdata[51:36];
    assign in_code       = s_axis_tdata[59:52];
    assign in_glyph_row  = s_axis_tdata[64:60];
    assign in_glyph_bits = s_axis_tdata[80:65];

    t_state      r_state, n_state;
    logic [8:0]  r_x, n_x, r_y, n_y, r_x0, n_x0, r_xend, n_xend, r_yend, n_yend;
    logic [15:0] r_color, n_color;
    logic        r_px_we, n_px_we;
    logic [8:0]  r_px_x, n_px_x, r_px_y, n_px_y;
    logic [15:0] r_px_color, n_px_color;
    logic [8:0]  r_char_x, n_char_x, r_char_y, n_char_y;
    logic [7:0]  r_code, n_code;
    logic [GA_W-1:0] r_g_raddr, n_g_raddr;
    logic [5:0]  r_grow, n_grow, r_rs, n_rs, r_h, n_h;
    logic [4:0]  r_k, n_k, r_c, n_c, r_cs, n_cs;
    logic [3:0]  r_j, n_j;
    logic        r_rd_on, n_rd_on;
    logic [15:0] r_hold, n_hold;
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data, n_out_data;
    logic [4:0]  r_font_w, n_font_w;
    logic [5:0]  r_font_h, n_font_h;

    logic        s_fire;
    logic        out_free;
    logic [15:0] fb_rdata, g_rdata;
    logic [17:0] fb_addr_full;
    logic [FA_W-1:0] fb_addr;
    logic        g_we;
    logic [GA_W-1:0] g_waddr;
    logic [8:0]  x_clip, y_clip;
    logic [9:0]  cx;
    logic signed [10:0] cy;
    logic        glyph_bit;
    logic [15:0] rd_raw;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // pixel op stage drives the frame RAM
    assign fb_addr_full = 18'(r_px_y) * 18'(SCREEN_WIDTH) + 18'(r_px_x);
    assign fb_addr      = FA_W'(fb_addr_full);

    fbde_ram #(
        .DATA_W (16),
        .DEPTH  (FB_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (r_px_we),
        .i_waddr (fb_addr),
        .i_wdata (r_px_color),
        .i_raddr (fb_addr),
        .o_rdata (fb_rdata)
    );

    assign g_we    = s_fire && (in_cmd == fbde_pkg::CMD_LOAD_GLYPH)
                     && ({1'b0, in_code} < GLYPHS);
    assign g_waddr = GA_W'({in_code, in_glyph_row});

    fbde_ram #(
        .DATA_W (16),
        .DEPTH  (G_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (in_glyph_bits),
        .i_raddr (r_g_raddr),
        .o_rdata (g_rdata)
    );

    assign x_clip = (in_x_b < SCR_W) ? in_x_b : SCR_W;
    assign y_clip = (in_y_b < SCR_H) ? in_y_b : SCR_H;

    // character pixel position; y may go negative through the height offset
    assign cx = {1'b0, r_char_x} + {6'd0, r_j};
    assign cy = $signed({2'b00, r_char_y}) + $signed({6'd0, r_k})
                - $signed({5'd0, r_h});
    assign glyph_bit = g_rdata[~r_c[3:0]];

    assign rd_raw = (r_state == ST_RD_HOLD) ? r_hold : (r_rd_on ? fb_rdata : 16'd0);

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_x0        = r_x0;
        n_xend      = r_xend;
        n_yend      = r_yend;
        n_color     = r_color;
        n_px_we     = 1'b0;
        n_px_x      = r_px_x;
        n_px_y      = r_px_y;
        n_px_color  = r_px_color;
        n_char_x    = r_char_x;
        n_char_y    = r_char_y;
        n_code      = r_code;
        n_g_raddr   = r_g_raddr;
        n_grow      = r_grow;
        n_rs        = r_rs;
        n_h         = r_h;
        n_k         = r_k;
        n_c         = r_c;
        n_cs        = r_cs;
        n_j         = r_j;
        n_rd_on     = r_rd_on;
        n_hold      = r_hold;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_font_w    = r_font_w;
        n_font_h    = r_font_h;

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (fbde_pkg::t_reg'(i_cfg_index))
                fbde_pkg::REG_FONT_WIDTH:  n_font_w = i_cfg_data[4:0];
                fbde_pkg::REG_FONT_HEIGHT: n_font_h = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (in_cmd)
                        fbde_pkg::CMD_PIXEL: begin
                            n_px_we    = (in_x_a < SCR_W) && (in_y_a < SCR_H);
                            n_px_x     = in_x_a;
                            n_px_y     = in_y_a;
                            n_px_color = in_color;
                        end
                        fbde_pkg::CMD_FILL_RECT: begin
                            n_x     = in_x_a;
                            n_y     = in_y_a;
                            n_x0    = in_x_a;
                            n_xend  = x_clip;
                            n_yend  = y_clip;
                            n_color = in_color;
                            if ((in_x_a < x_clip) && (in_y_a < y_clip)) begin
                                n_state = ST_FILL;
                            end
                        end
                        fbde_pkg::CMD_FILL_SCREEN: begin
                            n_x     = 9'd0;
                            n_y     = 9'd0;
                            n_x0    = 9'd0;
                            n_xend  = SCR_W;
                            n_yend  = SCR_H;
                            n_color = in_color;
                            n_state = ST_FILL;
                        end
                        fbde_pkg::CMD_DRAW_CHAR: begin
                            n_char_x  = in_x_a;
                            n_char_y  = in_y_a;
                            n_code    = in_code;
                            n_color   = in_color;
                            n_g_raddr = GA_W'({in_code, 5'd0});
                            n_grow    = 6'd0;
                            n_k       = 5'd0;
                            n_c       = 5'd0;
                            n_j       = 4'd0;
                            n_rs      = fbde_pkg::row_step(r_font_h);
                            n_cs      = fbde_pkg::col_step(r_font_w);
                            n_h       = fbde_pkg::font_h_eff(r_font_h);
                            if ({1'b0, in_code} < GLYPHS) begin
                                n_state = ST_CHAR_WAIT;
                            end
                        end
                        fbde_pkg::CMD_READ_PIXEL: begin
                            n_px_x  = in_x_a;
                            n_px_y  = in_y_a;
                            n_rd_on = (in_x_a < SCR_W) && (in_y_a < SCR_H);
                            n_state = ST_RD_ADDR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                n_px_we    = 1'b1;
                n_px_x     = r_x;
                n_px_y     = r_y;
                n_px_color = r_color;
                if (r_x + 9'd1 == r_xend) begin
                    n_x = r_x0;
                    n_y = r_y + 9'd1;
                    if (r_y + 9'd1 == r_yend) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_x = r_x + 9'd1;
                end
            end
            ST_CHAR_WAIT: begin
                n_state = ST_CHAR_COLS;
            end
            ST_CHAR_COLS: begin
                n_px_we    = glyph_bit && !cy[10] && (cy[9:0] < {1'b0, SCR_H})
                             && (cx < {1'b0, SCR_W});
                n_px_x     = cx[8:0];
                n_px_y     = cy[8:0];
                n_px_color = r_color;
                n_c        = r_c + r_cs;
                n_j        = r_j + 4'd1;
                if (n_c[4]) begin
                    n_c    = 5'd0;
                    n_j    = 4'd0;
                    n_grow = r_grow + r_rs;
                    n_k    = r_k + 5'd1;
                    if (n_grow[5]) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_g_raddr = GA_W'({r_code, n_grow[4:0]});
                        n_state   = ST_CHAR_WAIT;
                    end
                end
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA, ST_RD_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {fbde_pkg::expand5(rd_raw[4:0]),
                                   fbde_pkg::expand6(rd_raw[10:5]),
                                   fbde_pkg::expand5(rd_raw[15:11]),
                                   rd_raw};
                    n_state     = ST_IDLE;
                end else begin
                    n_hold  = rd_raw;
                    n_state = ST_RD_HOLD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset starts a zero fill of the whole screen
            r_state     <= ST_FILL;
            r_x         <= 9'd0;
            r_y         <= 9'd0;
            r_x0        <= 9'd0;
            r_xend      <= SCR_W;
            r_yend      <= SCR_H;
            r_color     <= 16'd0;
            r_px_we     <= 1'b0;
            r_out_valid <= 1'b0;
            r_font_w    <= fbde_pkg::FONT_W_RESET;
            r_font_h    <= fbde_pkg::FONT_H_RESET;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_x0        <= n_x0;
            r_xend      <= n_xend;
            r_yend      <= n_yend;
            r_color     <= n_color;
            r_px_we     <= n_px_we;
            r_px_x      <= n_px_x;
            r_px_y      <= n_px_y;
            r_px_color  <= n_px_color;
            r_char_x    <= n_char_x;
            r_char_y    <= n_char_y;
            r_code      <= n_code;
            r_g_raddr   <= n_g_raddr;
            r_grow      <= n_grow;
            r_rs        <= n_rs;
            r_h         <= n_h;
            r_k         <= n_k;
            r_c         <= n_c;
            r_cs        <= n_cs;
            r_j         <= n_j;
            r_rd_on     <= n_rd_on;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            r_font_w    <= n_font_w;
            r_font_h    <= n_font_h;
        end
    end

`ifndef ASSERT_OFF
    a_px_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_px_we |-> ((r_px_x < SCR_W) && (r_px_y < SCR_H)))
        else $error("frame write outside the screen");

    a_rd_after_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_DATA) |-> ($past(r_state) == ST_RD_ADDR))
        else $error("read data sampled without an address cycle");

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            (($past(r_state) == ST_RD_DATA) || ($past(r_state) == ST_RD_HOLD)))
        else $error("result raised outside a pixel read");

    a_glyph_stable_in_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CHAR_WAIT) || (r_state == ST_CHAR_COLS)) |-> !g_we)
        else $error("glyph store written while a character is drawn");
`endif

endmodule

`default_nettype wire

FILE: verif/framebuffer_draw_engine_test.sv
// ----------------------------------------------------------------------------
// framebuffer_draw_engine_test: self-checking bench for the drawing engine
// Drives draw, fill, glyph and read-back commands over the command stream,
// keeps its own copy of the frame and glyph stores, and checks every
// read-back transfer field by field. A directed table comes first, then
// random phases under several font settings with random stalls both sides.
// ----------------------------------------------------------------------------
module framebuffer_draw_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fbde_pkg::*;

    localparam int SCREEN_W         = 240;
    localparam int SCREEN_H         = 320;
    localparam int GLYPHS           = 256;
    localparam int GLYPH_ROWS       = 32;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 14;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 16;
    // a full-screen fill has no transfer while it runs; the limit leaves ample room
    localparam int WATCHDOG_LIMIT   = 400_000;

    // command codes the block leaves unused
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]  cmd;
        logic [8:0]  xa;
        logic [8:0]  ya;
        logic [8:0]  xb;
        logic [8:0]  yb;
        logic [15:0] color;
        logic [7:0]  code;
        logic [4:0]  grow;
        logic [15:0] gbits;
    } draw_cmd_t;

    // same layout as m_axis_tdata, lowest field last
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] raw;
    } readback_t;

    typedef struct {
        draw_cmd_t c;
        bit        typed;
        readback_t res;
    } stim_row_t;

    localparam readback_t NO_READ = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [5:0]  i_cfg_data;

    framebuffer_draw_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow state
    logic [15:0] pix_mem [0:SCREEN_W*SCREEN_H-1];
    logic [15:0] glyph_mem [0:GLYPHS*GLYPH_ROWS-1];
    bit          glyph_loaded [0:GLYPHS*GLYPH_ROWS-1];
    logic [4:0]  font_w_cfg = FONT_W_RESET;
    logic [5:0]  font_h_cfg = FONT_H_RESET;

    readback_t   pending_reads[$];
    stim_row_t   directed_rows[$];
    int          fail_count   = 0;
    int          idle_cycles  = 0;
    int          last_x       = 0;
    int          last_y       = 0;
    bit          quiet_input  = 0;
    bit          quiet_output = 0;
    bit          hold_off_req = 0;
    int          sink_gap     = 0;
    int          sink_hold    = 0;
    readback_t   want_rb;
    readback_t   got_rb;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------
    function automatic void plot(int x, int y, logic [15:0] color);
        if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H) return;
        pix_mem[y * SCREEN_W + x] = color;
    endfunction

    function automatic int eff_height();
        int h;
        h = font_h_cfg;
        if (h == 0) h = 1;
        if (h > 32) h = 32;
        return h;
    endfunction

    function automatic bit apply_cmd(draw_cmd_t c, output readback_t res);
        int          w, h, rs, cs;
        logic [15:0] bits;
        logic [15:0] v;
        res = NO_READ;
        case (c.cmd)
            CMD_PIXEL: begin
                plot(int'(c.xa), int'(c.ya), c.color);
            end
            CMD_FILL_RECT: begin
                for (int x = int'(c.xa); x < int'(c.xb); x++)
                    for (int y = int'(c.ya); y < int'(c.yb); y++)
                        plot(x, y, c.color);
            end
            CMD_FILL_SCREEN: begin
                foreach (pix_mem[i]) pix_mem[i] = c.color;
            end
            CMD_DRAW_CHAR: begin
                w = font_w_cfg;
                if (w == 0) w = 1;
                if (w > 16) w = 16;
                h  = eff_height();
                rs = 32 / h;
                cs = 16 / w;
                for (int r = 0; r < GLYPH_ROWS; r += rs) begin
                    bits = glyph_mem[int'(c.code) * GLYPH_ROWS + r];
                    for (int col = 0; col < 16; col += cs)
                        if (bits[15 - col])
                            plot(int'(c.xa) + col / cs, int'(c.ya) + r / rs - h, c.color);
                end
            end
            CMD_READ_PIXEL: begin
                v = 16'h0000;
                if (c.xa < SCREEN_W && c.ya < SCREEN_H)
                    v = pix_mem[int'(c.ya) * SCREEN_W + int'(c.xa)];
                res.raw   = v;
                res.red   = 8'(int'(v[15:11]) * 255 / 31);
                res.green = 8'(int'(v[10:5]) * 255 / 63);
                res.blue  = 8'(int'(v[4:0]) * 255 / 31);
                return 1'b1;
            end
            CMD_LOAD_GLYPH: begin
                glyph_mem[int'(c.code) * GLYPH_ROWS + int'(c.grow)]    = c.gbits;
                glyph_loaded[int'(c.code) * GLYPH_ROWS + int'(c.grow)] = 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic draw_cmd_t mk(logic [2:0] cmd, int xa = 0, int ya = 0, int xb = 0,
                                     int yb = 0, int color = 0, int code = 0, int grow = 0,
                                     int gbits = 0);
        draw_cmd_t c;
        c.cmd   = cmd;
        c.xa    = 9'(xa);
        c.ya    = 9'(ya);
        c.xb    = 9'(xb);
        c.yb    = 9'(yb);
        c.color = 16'(color);
        c.code  = 8'(code);
        c.grow  = 5'(grow);
        c.gbits = 16'(gbits);
        return c;
    endfunction

    function automatic readback_t rb(logic [15:0] raw, logic [7:0] r, logic [7:0] g,
                                     logic [7:0] b);
        readback_t x;
        x.raw   = raw;
        x.red   = r;
        x.green = g;
        x.blue  = b;
        return x;
    endfunction

    // every field random; the caller fixes what the command uses
    function automatic draw_cmd_t rand_cmd(logic [2:0] cmd);
        return mk(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endfunction

    function automatic logic [8:0] pick_x();
        return ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, SCREEN_W - 1))
                                            : 9'($urandom_range(0, 511));
    endfunction

    function automatic logic [8:0] pick_y();
        return ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, SCREEN_H - 1))
                                            : 9'($urandom_range(0, 511));
    endfunction

    // mostly back to back, some short gaps, the odd long one
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(draw_cmd_t c, bit typed, readback_t typed_res);
        readback_t res;
        int        gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.cmd;
        s_axis_tdata  <= {7'd0, c.gbits, c.grow, c.code, c.color, c.yb, c.xb, c.ya, c.xa};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (apply_cmd(c, res))
            pending_reads.push_back(typed ? typed_res : res);
        gap = quiet_input ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // glyph rows the character will read are loaded first, never left unwritten
    task automatic send_draw_char(draw_cmd_t c);
        draw_cmd_t ld;
        int        rs;
        rs = 32 / eff_height();
        for (int r = 0; r < GLYPH_ROWS; r += rs) begin
            if (!glyph_loaded[int'(c.code) * GLYPH_ROWS + r]) begin
                ld      = rand_cmd(CMD_LOAD_GLYPH);
                ld.code = c.code;
                ld.grow = 5'(r);
                send_item(ld, 1'b0, NO_READ);
            end
        end
        send_item(c, 1'b0, NO_READ);
    endtask

    task automatic write_reg(t_reg idx, logic [5:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_FONT_WIDTH) begin
            font_w_cfg = val[4:0];
        end else begin
            font_h_cfg = val;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int count);
        draw_cmd_t c;
        int        k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 22) begin
                c    = rand_cmd(CMD_PIXEL);
                c.xa = pick_x();
                c.ya = pick_y();
                last_x = c.xa;
                last_y = c.ya;
                send_item(c, 1'b0, NO_READ);
            end else if (k < 34) begin
                c    = rand_cmd(CMD_FILL_RECT);
                c.xa = pick_x();
                c.ya = pick_y();
                if ($urandom_range(0, 9) == 0) begin
                    c.xb = 9'($urandom_range(0, 511));
                    c.yb = 9'(c.ya + $urandom_range(0, 2));
                end else begin
                    c.xb = 9'(c.xa + $urandom_range(0, 12));
                    c.yb = 9'(c.ya + $urandom_range(0, 12));
                end
                last_x = c.xa;
                last_y = c.ya;
                send_item(c, 1'b0, NO_READ);
            end else if (k < 54) begin
                c      = rand_cmd(CMD_DRAW_CHAR);
                c.code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                c.xa   = 9'($urandom_range(0, 250));
                c.ya   = 9'($urandom_range(0, 360));
                last_x = c.xa;
                last_y = int'(c.ya) - eff_height();
                send_draw_char(c);
            end else if (k < 85) begin
                c = rand_cmd(CMD_READ_PIXEL);
                if ($urandom_range(0, 1) == 0) begin
                    c.xa = 9'(last_x + $urandom_range(0, 15));
                    c.ya = 9'(last_y + $urandom_range(0, 15));
                end else begin
                    c.xa = pick_x();
                    c.ya = pick_y();
                end
                send_item(c, 1'b0, NO_READ);
            end else if (k < 95) begin
                send_item(rand_cmd(CMD_LOAD_GLYPH), 1'b0, NO_READ);
            end else begin
                // unused codes: no effect, no result
                c = rand_cmd($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7);
                send_item(c, 1'b0, NO_READ);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // read-back sink: random stalls, and a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                sink_hold    = HOLD_OFF_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet_output) sink_gap = pick_gap();
            end
        end
    end

    // read-back checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_rb = m_axis_tdata;
            if (pending_reads.size() == 0) begin
                $error("read-back transfer with no read pending: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want_rb = pending_reads.pop_front();
                if (got_rb.raw !== want_rb.raw) begin
                    $error("read_raw: expected %h, got %h", want_rb.raw, got_rb.raw);
                    fail_count++;
                end
                if (got_rb.red !== want_rb.red) begin
                    $error("read_red: expected %h, got %h", want_rb.red, got_rb.red);
                    fail_count++;
                end
                if (got_rb.green !== want_rb.green) begin
                    $error("read_green: expected %h, got %h", want_rb.green, got_rb.green);
                    fail_count++;
                end
                if (got_rb.blue !== want_rb.blue) begin
                    $error("read_blue: expected %h, got %h", want_rb.blue, got_rb.blue);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** framebuffer_draw_engine: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [5:0] w_val, h_val;
        draw_cmd_t  c;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_FONT_WIDTH;
        i_cfg_data    = '0;
        foreach (pix_mem[i]) pix_mem[i] = 16'h0000;

        // directed table: typed results where they are obvious
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 0, 0), 1'b1, rb(16'h0000, 0, 0, 0)});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 239, 319), 1'b1, rb(16'h0000, 0, 0, 0)});
        directed_rows.push_back('{mk(CMD_PIXEL, 0, 0, 0, 0, 16'hFFFF), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 0, 0), 1'b1,
                                  rb(16'hFFFF, 8'hFF, 8'hFF, 8'hFF)});
        directed_rows.push_back('{mk(CMD_PIXEL, 239, 319, 0, 0, 16'h0841), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 239, 319), 1'b1,
                                  rb(16'h0841, 8'h08, 8'h08, 8'h08)});
        // off-screen writes are dropped and off-screen reads give zero
        directed_rows.push_back('{mk(CMD_PIXEL, 240, 0, 0, 0, 16'h1234), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 240, 0), 1'b1, rb(16'h0000, 0, 0, 0)});
        directed_rows.push_back('{mk(CMD_PIXEL, 511, 511, 0, 0, 16'hAAAA), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 511, 511), 1'b1, rb(16'h0000, 0, 0, 0)});
        // empty rectangles, then one clipped at the far corner
        directed_rows.push_back('{mk(CMD_FILL_RECT, 10, 10, 5, 20, 16'hFFFF), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_FILL_RECT, 10, 10, 20, 10, 16'hFFFF), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_FILL_RECT, 230, 310, 511, 511, 16'hF800), 1'b0,
                                  NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 239, 319), 1'b1,
                                  rb(16'hF800, 8'hFF, 8'h00, 8'h00)});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 229, 310), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_FILL_SCREEN, 0, 0, 0, 0, 16'h07E0), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 100, 100), 1'b1,
                                  rb(16'h07E0, 8'h00, 8'hFF, 8'h00)});
        directed_rows.push_back('{mk(CMD_LOAD_GLYPH, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF), 1'b0,
                                  NO_READ});
        directed_rows.push_back('{mk(CMD_LOAD_GLYPH, 0, 0, 0, 0, 0, 0, 31, 16'h0000), 1'b0,
                                  NO_READ});
        directed_rows.push_back('{mk(CMD_DRAW_CHAR, 0, 32, 0, 0, 16'h001F, 0), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 0, 0), 1'b0, NO_READ});
        // whole glyph lands above the screen
        directed_rows.push_back('{mk(CMD_DRAW_CHAR, 0, 0, 0, 0, 16'hFFFF, 255), 1'b0, NO_READ});
        // partly off the right and top edges
        directed_rows.push_back('{mk(CMD_DRAW_CHAR, 232, 8, 0, 0, 16'hF81F, 1), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 239, 0), 1'b0, NO_READ});
        directed_rows.push_back('{rand_cmd(CMD_SPARE_6), 1'b0, NO_READ});
        directed_rows.push_back('{rand_cmd(CMD_SPARE_7), 1'b0, NO_READ});
        directed_rows.push_back('{mk(CMD_READ_PIXEL, 0, 31), 1'b0, NO_READ});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the block clears its frame store first; the first transfer waits for it
        foreach (directed_rows[i]) begin
            if (directed_rows[i].c.cmd == CMD_DRAW_CHAR) begin
                send_draw_char(directed_rows[i].c);
            end else begin
                send_item(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].res);
            end
        end
        settle();

        for (int p = 0; p < PHASES; p++) begin
            // zero, oversize (with the unused top data bit), minimum, reset, random
            case (p)
                0:       begin w_val = 6'd0;  h_val = 6'd0;  end
                1:       begin w_val = 6'h3F; h_val = 6'h3F; end
                2:       begin w_val = 6'd1;  h_val = 6'd1;  end
                3:       begin w_val = 6'd16; h_val = 6'd32; end
                default: begin
                    w_val = 6'($urandom_range(0, 63));
                    h_val = 6'($urandom_range(0, 63));
                end
            endcase
            write_reg(REG_FONT_WIDTH, w_val);
            write_reg(REG_FONT_HEIGHT, h_val);
            quiet_input  = (p == 3);
            quiet_output = (p == 3);

            if (p == 1) begin
                // sink holds off while reads keep coming, so the input backs up
                quiet_input  = 1'b1;
                hold_off_req = 1'b1;
                for (int n = 0; n < 16; n++) begin
                    c    = rand_cmd(CMD_READ_PIXEL);
                    c.xa = pick_x();
                    c.ya = pick_y();
                    send_item(c, 1'b0, NO_READ);
                end
                quiet_input = 1'b0;
            end
            if (p == 2) begin
                send_item(rand_cmd(CMD_FILL_SCREEN), 1'b0, NO_READ);
            end

            run_random(ITEMS_PER_PHASE);

            // a trailing read drains everything ahead of it
            c    = rand_cmd(CMD_READ_PIXEL);
            c.xa = pick_x();
            c.ya = pick_y();
            send_item(c, 1'b0, NO_READ);
            settle();
        end

        if (fail_count == 0) begin
            $display("** framebuffer_draw_engine: PASSED **");
        end else begin
            $display("** framebuffer_draw_engine: FAILED **");
        end
        $finish;
    end

endmodule
